### sv/pica_pkg.sv
// Shared types, codes and saturation helpers for the PI controller.
`timescale 1ns / 1ps
`default_nettype none

package pica_pkg;

    localparam int unsigned DIV_STEPS = 64;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // Command carried on the input tuser.
    typedef enum logic [1:0] {
        CMD_RUN   = 2'd0,
        CMD_FB    = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // Result status carried on the output tuser.
    localparam logic [1:0] STAT_NORMAL = 2'd0;
    localparam logic [1:0] STAT_HIGH   = 2'd1;
    localparam logic [1:0] STAT_LOW    = 2'd2;
    localparam logic [1:0] STAT_DIV0   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [1:0] REG_OUT_LIMIT  = 2'd2;
    localparam logic [1:0] REG_PERIOD     = 2'd3;

    // Datapath micro-operations issued by the controller.
    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_ERR,
        DP_MUL_P,
        DP_MUL_K,
        DP_KE,
        DP_MUL_I,
        DP_PRED,
        DP_DRIVE,
        DP_FIN_RUN,
        DP_FB_MUL,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_FIN_DIV,
        DP_FIN_OTHER
    } dp_op_t;

    // Status returned by the datapath.
    typedef struct packed {
        cmd_t cmd;
        logic fb_equal;
        logic req_zero;
        logic div_last;
    } dp_stat_t;

    // Saturate a 66-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v[65:31] == '0 || v[65:31] == '1) begin
            r = v[31:0];
        end else begin
            r = v[65] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

    // Saturate a 34-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == '0 || v[33:31] == '1) begin
            r = v[31:0];
        end else begin
            r = v[33] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/pica_ctrl.sv
// Sequencing state machine for the PI controller.
`timescale 1ns / 1ps
`default_nettype none

module pica_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire pica_pkg::dp_stat_t stat,
    output pica_pkg::dp_op_t        op
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL_P,
        ST_MUL_K,
        ST_KE,
        ST_MUL_I,
        ST_PRED,
        ST_DRIVE,
        ST_FIN_RUN,
        ST_DIV_INIT,
        ST_DIV,
        ST_FIN_DIV,
        ST_FIN_OTHER
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;
    logic   out_free;
    logic   commit;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;
    assign out_free = !valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        op         = pica_pkg::DP_NONE;
        commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op         = pica_pkg::DP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (stat.cmd)
                    pica_pkg::CMD_RUN: begin
                        op         = pica_pkg::DP_ERR;
                        state_next = ST_MUL_P;
                    end
                    pica_pkg::CMD_FB: begin
                        op = pica_pkg::DP_FB_MUL;
                        if (stat.fb_equal || stat.req_zero) begin
                            state_next = ST_FIN_OTHER;
                        end else begin
                            state_next = ST_DIV_INIT;
                        end
                    end
                    default: begin
                        state_next = ST_FIN_OTHER;
                    end
                endcase
            end
            ST_MUL_P: begin
                op         = pica_pkg::DP_MUL_P;
                state_next = ST_MUL_K;
            end
            ST_MUL_K: begin
                op         = pica_pkg::DP_MUL_K;
                state_next = ST_KE;
            end
            ST_KE: begin
                op         = pica_pkg::DP_KE;
                state_next = ST_MUL_I;
            end
            ST_MUL_I: begin
                op         = pica_pkg::DP_MUL_I;
                state_next = ST_PRED;
            end
            ST_PRED: begin
                op         = pica_pkg::DP_PRED;
                state_next = ST_DRIVE;
            end
            ST_DRIVE: begin
                op         = pica_pkg::DP_DRIVE;
                state_next = ST_FIN_RUN;
            end
            ST_DIV_INIT: begin
                op         = pica_pkg::DP_DIV_INIT;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                op = pica_pkg::DP_DIV_STEP;
                if (stat.div_last) begin
                    state_next = ST_FIN_DIV;
                end
            end
            ST_FIN_RUN, ST_FIN_DIV, ST_FIN_OTHER: begin
                // Hold until the output register is free.
                if (out_free) begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                    unique case (state_reg)
                        ST_FIN_RUN: op = pica_pkg::DP_FIN_RUN;
                        ST_FIN_DIV: op = pica_pkg::DP_FIN_DIV;
                        default:    op = pica_pkg::DP_FIN_OTHER;
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (commit) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

### sv/pica_dp.sv
// Datapath of the PI controller: shared multiplier, divider, integrator.
`timescale 1ns / 1ps
`default_nettype none

module pica_dp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_addr,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic [1:0]         in_cmd,
    input  wire logic [127:0]       in_data,
    input  wire pica_pkg::dp_op_t   op,
    output pica_pkg::dp_stat_t      stat,
    output logic [63:0]             res_data,
    output logic [1:0]              res_status
);

    // Configuration registers
    logic [30:0] prop_gain_reg;
    logic [30:0] integ_gain_reg;
    logic [30:0] out_limit_reg;
    logic [31:0] period_reg;

    // Item and working registers
    pica_pkg::cmd_t     cmd_reg;
    logic signed [31:0] sp_reg, ms_reg, app_reg, req_reg;
    logic signed [31:0] err_reg, p_reg, ke_reg, pred_reg, drv_reg;
    logic signed [31:0] integ_reg, integ_next;
    logic signed [65:0] prod_reg;

    // Divider registers
    logic [63:0]                    dvd_reg;
    logic [31:0]                    rem_reg;
    logic [31:0]                    den_reg;
    logic                           qneg_reg;
    logic [pica_pkg::DIV_CNT_W-1:0] cnt_reg;

    // Result registers
    logic signed [31:0] res_drive_reg, res_integ_reg;
    logic [1:0]         res_status_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_prod;
    logic signed [31:0] sh16_sat, sh32_sat;
    logic signed [33:0] err_sum;
    logic signed [31:0] lim_s, imax, imin;
    logic signed [31:0] fin_drive, fin_integ;
    logic [1:0]         fin_status;
    logic [32:0]        trial;
    logic               trial_ge;
    logic signed [31:0] q_sat;
    logic [63:0]        num_mag;

    assign stat.cmd      = cmd_reg;
    assign stat.fb_equal = (app_reg == req_reg);
    assign stat.req_zero = (req_reg == '0);
    assign stat.div_last = (cnt_reg == pica_pkg::DIV_CNT_W'(pica_pkg::DIV_STEPS - 1));

    assign res_data   = {res_integ_reg, res_drive_reg};
    assign res_status = res_status_reg;

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            pica_pkg::DP_MUL_P: begin
                mul_a = signed'({2'b00, prop_gain_reg});
                mul_b = 33'(err_reg);
            end
            pica_pkg::DP_MUL_K: begin
                mul_a = signed'({2'b00, integ_gain_reg});
                mul_b = 33'(err_reg);
            end
            pica_pkg::DP_MUL_I: begin
                mul_a = 33'(ke_reg);
                mul_b = signed'({1'b0, period_reg});
            end
            pica_pkg::DP_FB_MUL: begin
                mul_a = 33'(integ_reg);
                mul_b = 33'(app_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;
    assign sh16_sat = pica_pkg::sat66(prod_reg >>> 16);
    assign sh32_sat = pica_pkg::sat66(prod_reg >>> 32);
    assign err_sum  = 34'(sp_reg) - 34'(ms_reg);

    // Clamp and anti-windup
    always_comb begin
        lim_s      = signed'({1'b0, out_limit_reg});
        imax       = pica_pkg::sat34(34'(lim_s) - 34'(p_reg));
        imin       = pica_pkg::sat34(-34'(lim_s) - 34'(p_reg));
        fin_drive  = drv_reg;
        fin_integ  = pred_reg;
        fin_status = pica_pkg::STAT_NORMAL;
        if (drv_reg > lim_s) begin
            fin_drive  = lim_s;
            fin_status = pica_pkg::STAT_HIGH;
            if (pred_reg > imax) begin
                fin_integ = imax;
            end
        end else if (drv_reg < -lim_s) begin
            fin_drive  = -lim_s;
            fin_status = pica_pkg::STAT_LOW;
            if (pred_reg < imin) begin
                fin_integ = imin;
            end
        end
    end

    // Restoring divide step and quotient saturation
    always_comb begin
        trial    = {rem_reg, dvd_reg[63]};
        trial_ge = (trial >= {1'b0, den_reg});
        num_mag  = prod_reg[65] ? 64'(-prod_reg) : prod_reg[63:0];
        if (qneg_reg) begin
            if (dvd_reg[63:32] != '0 || (dvd_reg[31] && dvd_reg[30:0] != '0)) begin
                q_sat = pica_pkg::Q_MIN;
            end else begin
                q_sat = -signed'(dvd_reg[31:0]);
            end
        end else begin
            if (dvd_reg[63:31] != '0) begin
                q_sat = pica_pkg::Q_MAX;
            end else begin
                q_sat = signed'(dvd_reg[31:0]);
            end
        end
    end

    always_comb begin
        integ_next = integ_reg;
        case (op)
            pica_pkg::DP_FIN_RUN: integ_next = fin_integ;
            pica_pkg::DP_FIN_DIV: integ_next = q_sat;
            pica_pkg::DP_FIN_OTHER: begin
                if (cmd_reg == pica_pkg::CMD_CLEAR) begin
                    integ_next = '0;
                end
            end
            default: integ_next = integ_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            out_limit_reg  <= '0;
            period_reg     <= '0;
            integ_reg      <= '0;
        end else begin
            integ_reg <= integ_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    pica_pkg::REG_PROP_GAIN:  prop_gain_reg  <= cfg_wdata[30:0];
                    pica_pkg::REG_INTEG_GAIN: integ_gain_reg <= cfg_wdata[30:0];
                    pica_pkg::REG_OUT_LIMIT:  out_limit_reg  <= cfg_wdata[30:0];
                    pica_pkg::REG_PERIOD:     period_reg     <= cfg_wdata;
                    default:                  period_reg     <= period_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (op)
            pica_pkg::DP_LOAD: begin
                cmd_reg <= pica_pkg::cmd_t'(in_cmd);
                sp_reg  <= in_data[31:0];
                ms_reg  <= in_data[63:32];
                app_reg <= in_data[95:64];
                req_reg <= in_data[127:96];
            end
            pica_pkg::DP_ERR:   err_reg <= pica_pkg::sat34(err_sum);
            pica_pkg::DP_MUL_P: prod_reg <= mul_prod;
            pica_pkg::DP_MUL_K: begin
                p_reg    <= sh16_sat;
                prod_reg <= mul_prod;
            end
            pica_pkg::DP_KE:     ke_reg   <= sh16_sat;
            pica_pkg::DP_MUL_I:  prod_reg <= mul_prod;
            pica_pkg::DP_PRED:   pred_reg <= pica_pkg::sat34(34'(integ_reg) + 34'(sh32_sat));
            pica_pkg::DP_DRIVE:  drv_reg  <= pica_pkg::sat34(34'(p_reg) + 34'(pred_reg));
            pica_pkg::DP_FB_MUL: prod_reg <= mul_prod;
            pica_pkg::DP_DIV_INIT: begin
                dvd_reg  <= num_mag;
                rem_reg  <= '0;
                den_reg  <= req_reg[31] ? 32'(-req_reg) : req_reg;
                qneg_reg <= prod_reg[65] ^ req_reg[31];
                cnt_reg  <= '0;
            end
            pica_pkg::DP_DIV_STEP: begin
                rem_reg <= trial_ge ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
                dvd_reg <= {dvd_reg[62:0], trial_ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            pica_pkg::DP_FIN_RUN: begin
                res_drive_reg  <= fin_drive;
                res_integ_reg  <= fin_integ;
                res_status_reg <= fin_status;
            end
            pica_pkg::DP_FIN_DIV: begin
                res_drive_reg  <= '0;
                res_integ_reg  <= q_sat;
                res_status_reg <= pica_pkg::STAT_NORMAL;
            end
            pica_pkg::DP_FIN_OTHER: begin
                res_drive_reg  <= '0;
                res_integ_reg  <= integ_next;
                res_status_reg <= (cmd_reg == pica_pkg::CMD_FB && !stat.fb_equal)
                                  ? pica_pkg::STAT_DIV0 : pica_pkg::STAT_NORMAL;
            end
            default: begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/pi_controller_clamp_antiwindup.sv
// Top level of the Q16.16 PI controller with clamping anti-windup.
// Run word: load, error, P product, Ki product, Ki*e, period product, prediction, drive, clamp.
// Feedback word with a divide: product, divider set-up, the 64-step bit-serial divider, finish.
// Feedback without divide, clear and the spare command: decode, then finish.
// One word at a time; a new word is accepted while the last result waits on m_tready.
// Reset (aresetn low, synchronous) clears the gains, limit, period and integrator.
`timescale 1ns / 1ps
`default_nettype none

module pi_controller_clamp_antiwindup (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Configuration write port: index 0 prop_gain, 1 integ_gain,
    // 2 out_limit, 3 sample_period
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [31:0]  cfg_wdata,
    // Input words
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,  // setpoint, measured, applied_output, requested_output
    input  wire logic [1:0]   s_tuser,  // command
    // Result words
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,  // drive, integrator_now
    output logic [1:0]        m_tuser   // status
);

    // Controller to datapath: one micro-op per cycle; datapath reports
    // the decoded command, the feedback special cases and divider progress.
    pica_pkg::dp_op_t   op;
    pica_pkg::dp_stat_t stat;

    // The controller owns both handshakes; the datapath owns all payload
    // and holds the finished result stable while m_tvalid is high.
    pica_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .op       (op)
    );

    // Shared 33x33 multiplier, saturating adders, clamp logic and a
    // restoring divider for the feedback rescale.
    pica_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_cmd     (s_tuser),
        .in_data    (s_tdata),
        .op         (op),
        .stat       (stat),
        .res_data   (m_tdata),
        .res_status (m_tuser)
    );

endmodule

`default_nettype wire

### sv/pica_chk.sv
// Port-level checker for the PI controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pica_chk (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [63:0]  m_tdata,
    input wire logic [1:0]   m_tuser
);

    // Result held until taken.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped before it was taken");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // One word in flight: the input side closes after an accept.
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while one is in flight");

    // A divide-by-zero report never carries a drive value.
    a_div0_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == pica_pkg::STAT_DIV0 |-> m_tdata[31:0] == '0)
        else $error("nonzero drive on a feedback result");

endmodule

bind pi_controller_clamp_antiwindup pica_chk u_chk (.*);

`default_nettype wire

### tb/pi_controller_clamp_antiwindup_tb.sv
// Self-checking testbench for the Q16.16 PI controller with clamping anti-windup.
`timescale 1ns / 1ps

module pi_controller_clamp_antiwindup_tb;

    import pica_pkg::*;

    // Hold off register writes this many cycles after the last result word.
    localparam int SETTLE_CYCLES = 4;
    // Stop idling on both sides once this few schedule entries remain.
    localparam int CALM_TAIL = 120;
    localparam int RAND_PHASES = 8;
    localparam int WORDS_PER_PHASE = 166;
    // Slowest correct run is about 1.7 ms; allow several times that.
    localparam longint LIMIT_NS = 10_000_000;

    typedef enum logic [1:0] {
        ITEM_WORD,
        ITEM_CFG,
        ITEM_DRAIN
    } item_kind_t;

    // One schedule entry: an input word, a register write or a drain point.
    typedef struct {
        item_kind_t         kind;
        cmd_t               cmd;
        logic signed [31:0] setpoint;
        logic signed [31:0] measured;
        logic signed [31:0] applied;
        logic signed [31:0] requested;
        logic [1:0]         addr;
        logic [31:0]        value;
    } item_t;

    typedef struct {
        logic signed [31:0] drive;
        logic signed [31:0] integ;
        logic [1:0]         status;
    } ctrl_out_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_addr  = '0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata   = '0;  // setpoint, measured, applied_output, requested_output
    logic [1:0]   s_tuser   = '0;  // command
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [63:0]  m_tdata;         // drive, integrator_now
    logic [1:0]   m_tuser;         // status

    item_t     cmd_schedule[$];
    ctrl_out_t awaited_results[$];
    item_t     cur_word;

    // Shadow copy of the controller: registers and integrator.
    longint kp_sh, ki_sh, lim_sh, ts_sh;
    int     integ_sh;

    int in_flight = 0;
    bit tail_calm = 1'b0;
    bit failed    = 1'b0;

    always #6 aclk = ~aclk;

    pi_controller_clamp_antiwindup DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Saturate an exact 64-bit value to the signed 32-bit range.
    function automatic int clip32(input longint v);
        if (v > longint'(Q_MAX)) return Q_MAX;
        if (v < longint'(Q_MIN)) return Q_MIN;
        return int'(v);
    endfunction

    // Advance the shadow controller by one word and return the result word it gives.
    function automatic ctrl_out_t control_step(input item_t w);
        ctrl_out_t r;
        int err, p, ke, inc, pred, drv, bound;
        r.drive  = '0;
        r.status = STAT_NORMAL;
        case (w.cmd)
            CMD_RUN: begin
                err  = clip32(longint'(w.setpoint) - longint'(w.measured));
                // Arithmetic shifts floor toward minus infinity.
                p    = clip32((kp_sh * longint'(err)) >>> 16);
                ke   = clip32((ki_sh * longint'(err)) >>> 16);
                inc  = clip32((longint'(ke) * ts_sh) >>> 32);
                pred = clip32(longint'(integ_sh) + longint'(inc));
                drv  = clip32(longint'(p) + longint'(pred));
                if (longint'(drv) > lim_sh) begin
                    // Clamp high: pull the integrator down to limit - P at most.
                    bound    = clip32(lim_sh - longint'(p));
                    drv      = int'(lim_sh);
                    r.status = STAT_HIGH;
                    if (pred > bound) pred = bound;
                end else if (longint'(drv) < -lim_sh) begin
                    // Clamp low: raise the integrator to -limit - P at least.
                    bound    = clip32(-lim_sh - longint'(p));
                    drv      = int'(-lim_sh);
                    r.status = STAT_LOW;
                    if (pred < bound) pred = bound;
                end
                integ_sh = pred;
                r.drive  = drv;
            end
            CMD_FB: begin
                // Equal outputs leave the integrator alone; zero request is flagged.
                if (w.applied != w.requested) begin
                    if (w.requested == 0) begin
                        r.status = STAT_DIV0;
                    end else begin
                        integ_sh = clip32((longint'(integ_sh) * longint'(w.applied))
                                          / longint'(w.requested));
                    end
                end
            end
            CMD_CLEAR: begin
                integ_sh = 0;
            end
            default: begin
            end
        endcase
        r.integ = integ_sh;
        return r;
    endfunction

    // Mostly values within +/-32.0, some full-range, some at the edges.
    function automatic logic signed [31:0] rand_q();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = Q_MAX;
                    1: v = Q_MIN;
                    2: v = 32'sd0;
                    3: v = -32'sd1;
                    default: v = 32'sd1;
                endcase
            end
            1, 2, 3: v = $urandom;
            default: v = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
        endcase
        return v;
    endfunction

    // Register value for a random phase: zero, all ones, any, or a working setting.
    function automatic logic [31:0] rand_reg(input logic [1:0] addr);
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = 32'hFFFF_FFFF;
            2: v = $urandom;
            default: begin
                case (addr)
                    REG_PROP_GAIN:  v = $urandom_range(0, 32'h0004_0000);
                    REG_INTEG_GAIN: v = $urandom_range(0, 32'h0020_0000);
                    REG_OUT_LIMIT:  v = $urandom_range(32'h0000_8000, 32'h0400_0000);
                    default:        v = $urandom_range(32'h0010_0000, 32'h1000_0000);
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic queue_word(input cmd_t op, input logic signed [31:0] sp,
                              input logic signed [31:0] ms, input logic signed [31:0] app,
                              input logic signed [31:0] req);
        item_t it;
        it = '{ITEM_WORD, op, sp, ms, app, req, 2'd0, 32'd0};
        cmd_schedule.push_back(it);
    endtask

    task automatic queue_cfg(input logic [1:0] addr, input logic [31:0] value);
        item_t it;
        it = '{ITEM_CFG, CMD_NOP, 32'sd0, 32'sd0, 32'sd0, 32'sd0, addr, value};
        cmd_schedule.push_back(it);
    endtask

    task automatic queue_drain();
        item_t it;
        it = '{ITEM_DRAIN, CMD_NOP, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 2'd0, 32'd0};
        cmd_schedule.push_back(it);
    endtask

    // Word driver: pull entries off the schedule, present words, write registers
    // only when nothing is in flight, and predict each word as it is accepted.
    always @(posedge aclk) begin : drive_words
        item_t       head;
        logic        nxt_valid;
        logic        nxt_wr;
        int          idle_left;
        int          settle;
        int          tx_pct;
        int unsigned n_acc;
        nxt_valid = s_tvalid;
        nxt_wr    = 1'b0;
        if (!aresetn) begin
            kp_sh     = 0;
            ki_sh     = 0;
            lim_sh    = 0;
            ts_sh     = 0;
            integ_sh  = 0;
            in_flight = 0;
            idle_left = 0;
            settle    = 0;
            tx_pct    = 0;
            n_acc     = 0;
            s_tvalid  <= 1'b0;
            cfg_wr_en <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(control_step(cur_word));
                in_flight++;
                nxt_valid = 1'b0;
                n_acc++;
                // Reroll the gap rate now and then; zero gives a stretch with no gaps.
                if (n_acc % 64 == 0) begin
                    tx_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
                end
                if (!tail_calm && $urandom_range(0, 99) < tx_pct) begin
                    idle_left = $urandom_range(1, 15);
                end
            end
            if (m_tvalid && m_tready) in_flight--;
            settle = (in_flight == 0) ? ((settle < SETTLE_CYCLES) ? settle + 1 : settle) : 0;

            if (idle_left != 0) begin
                idle_left--;
            end else if (!nxt_valid && cmd_schedule.size() != 0) begin
                head = cmd_schedule[0];
                case (head.kind)
                    ITEM_WORD: begin
                        void'(cmd_schedule.pop_front());
                        cur_word  = head;
                        s_tdata   <= {head.requested, head.applied, head.measured,
                                      head.setpoint};
                        s_tuser   <= head.cmd;
                        nxt_valid = 1'b1;
                    end
                    ITEM_CFG: begin
                        // Write only once the block has gone quiet.
                        if (settle >= SETTLE_CYCLES) begin
                            void'(cmd_schedule.pop_front());
                            case (head.addr)
                                REG_PROP_GAIN:  kp_sh  = longint'(head.value[30:0]);
                                REG_INTEG_GAIN: ki_sh  = longint'(head.value[30:0]);
                                REG_OUT_LIMIT:  lim_sh = longint'(head.value[30:0]);
                                default:        ts_sh  = longint'(head.value);
                            endcase
                            cfg_addr  <= head.addr;
                            cfg_wdata <= head.value;
                            nxt_wr    = 1'b1;
                        end
                    end
                    default: begin
                        // Drain point: hold off until every result word is back.
                        if (in_flight == 0) void'(cmd_schedule.pop_front());
                    end
                endcase
            end
            tail_calm <= (cmd_schedule.size() < CALM_TAIL);
            s_tvalid  <= nxt_valid;
            cfg_wr_en <= nxt_wr;
        end
    end

    // Result monitor: stall m_tready in bursts, check each result word in order.
    always @(posedge aclk) begin : take_results
        ctrl_out_t   want;
        logic        nxt_ready;
        int          stall_left;
        int          rx_pct;
        int unsigned rx_cycles;
        if (!aresetn) begin
            stall_left = 0;
            rx_pct     = 0;
            rx_cycles  = 0;
            m_tready   <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result word with none awaited: drive %0d integrator_now %0d status %0d",
                           $signed(m_tdata[31:0]), $signed(m_tdata[63:32]), m_tuser);
                    failed = 1'b1;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tdata[31:0] !== want.drive) begin
                        $error("drive: expected %0d, actual %0d",
                               want.drive, $signed(m_tdata[31:0]));
                        failed = 1'b1;
                    end
                    if (m_tdata[63:32] !== want.integ) begin
                        $error("integrator_now: expected %0d, actual %0d",
                               want.integ, $signed(m_tdata[63:32]));
                        failed = 1'b1;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        failed = 1'b1;
                    end
                end
            end
            rx_cycles++;
            if (rx_cycles % 128 == 0) begin
                rx_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 15);
            end
            if (stall_left != 0) begin
                stall_left--;
                nxt_ready = 1'b0;
            end else if (!tail_calm && $urandom_range(0, 99) < rx_pct) begin
                stall_left = $urandom_range(0, 14);
                nxt_ready  = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
            m_tready <= nxt_ready;
        end
    end

    initial begin : run_ctl
        int                 ph;
        int                 k;
        logic signed [31:0] sp, ms, app, req;
        cmd_t               op;

        // Reset values: all gains and the limit are zero, so drive stays zero.
        queue_word(CMD_RUN, 32'sh0001_0000, 32'sh0000_0000, 32'sd0, 32'sd0);
        queue_word(CMD_FB, 32'sd0, 32'sd0, 32'sh0001_0000, 32'sh0002_0000);

        // Working setting: Kp 1.0, Ki 2.0, limit 10.0, period 0.5.
        queue_cfg(REG_PROP_GAIN, 32'h0001_0000);
        queue_cfg(REG_INTEG_GAIN, 32'h0002_0000);
        queue_cfg(REG_OUT_LIMIT, 32'h000A_0000);
        queue_cfg(REG_PERIOD, 32'h8000_0000);
        queue_word(CMD_RUN, 32'sh0003_0000, 32'sh0001_0000, 32'sd0, 32'sd0);
        queue_word(CMD_RUN, 32'sh0003_0000, 32'sh0001_0000, Q_MAX, Q_MIN);
        // Feedback: equal outputs, zero request, plain rescale.
        queue_word(CMD_FB, 32'sd0, 32'sd0, 32'sh0003_0000, 32'sh0003_0000);
        queue_word(CMD_FB, 32'sd0, 32'sd0, 32'sh0001_0000, 32'sd0);
        queue_word(CMD_FB, 32'sd0, 32'sd0, -32'sh0003_0000, 32'sh0002_0000);
        // Error saturates both ways and the output clamps high then low.
        queue_word(CMD_RUN, Q_MAX, Q_MIN, 32'sd0, 32'sd0);
        queue_word(CMD_RUN, Q_MIN, Q_MAX, 32'sd0, 32'sd0);
        // Rescale that overflows, equal at the extreme, zero applied.
        queue_word(CMD_FB, Q_MAX, Q_MIN, Q_MIN, 32'sd1);
        queue_word(CMD_FB, 32'sd0, 32'sd0, Q_MAX, -32'sd1);
        queue_word(CMD_FB, 32'sd0, 32'sd0, Q_MIN, Q_MIN);
        queue_word(CMD_FB, 32'sd0, 32'sd0, 32'sd0, Q_MAX);
        queue_word(CMD_CLEAR, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
        queue_word(CMD_NOP, Q_MIN, Q_MAX, -32'sd1, 32'sd1);
        // One-LSB negative error: flooring, not truncation.
        queue_word(CMD_RUN, -32'sd1, 32'sd0, 32'sd0, 32'sd0);

        // Every register at all ones: the 31-bit ones drop the top bit.
        queue_cfg(REG_PROP_GAIN, 32'hFFFF_FFFF);
        queue_cfg(REG_INTEG_GAIN, 32'hFFFF_FFFF);
        queue_cfg(REG_OUT_LIMIT, 32'hFFFF_FFFF);
        queue_cfg(REG_PERIOD, 32'hFFFF_FFFF);
        queue_word(CMD_RUN, Q_MAX, Q_MIN, 32'sd0, 32'sd0);
        queue_word(CMD_RUN, Q_MIN, Q_MAX, 32'sd0, 32'sd0);
        queue_word(CMD_RUN, 32'sd1, 32'sd0, 32'sd0, 32'sd0);
        // Zero limit: any nonzero drive clamps.
        queue_cfg(REG_OUT_LIMIT, 32'h0000_0000);
        queue_word(CMD_RUN, 32'sd0, 32'sd1, 32'sd0, 32'sd0);
        queue_word(CMD_RUN, 32'sd0, 32'sd0, 32'sd0, 32'sd0);

        // Random phases, each with a fresh setting and a drain halfway through.
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            queue_cfg(REG_PROP_GAIN, rand_reg(REG_PROP_GAIN));
            queue_cfg(REG_INTEG_GAIN, rand_reg(REG_INTEG_GAIN));
            queue_cfg(REG_OUT_LIMIT, rand_reg(REG_OUT_LIMIT));
            queue_cfg(REG_PERIOD, rand_reg(REG_PERIOD));
            for (k = 0; k < WORDS_PER_PHASE; k++) begin
                if (k == WORDS_PER_PHASE / 2) queue_drain();
                sp  = rand_q();
                ms  = rand_q();
                app = rand_q();
                req = rand_q();
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: op = CMD_RUN;
                    12, 13, 14, 15, 16: begin
                        op = CMD_FB;
                        case ($urandom_range(0, 5))
                            0: app = req;
                            1: req = 32'sd0;
                            2, 3: app = req + $urandom_range(0, 32'h4000) - 32'h2000;
                            default: begin
                            end
                        endcase
                    end
                    17: op = CMD_CLEAR;
                    default: op = CMD_NOP;
                endcase
                queue_word(op, sp, ms, app, req);
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_schedule.size() != 0 || s_tvalid || in_flight != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);

        if (!failed && awaited_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
